// ===== design/psmst_pkg.sv =====
// Package for the point-set minimum spanning tree core.
// Holds the shared sizes and the pipeline tag type. It depends on nothing else.
package psmst_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned CoordW    = 16;
  localparam int unsigned SqW       = 2 * CoordW;
  localparam int unsigned LenW      = SqW + 1;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [CoordW-1:0] coord_t;
  typedef logic [SqW-1:0]    sq_t;
  typedef logic [LenW-1:0]   len_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic valid;
    idx_t k;
  } tag_t;

endpackage

// ===== design/point_set_prim_mst_core.sv =====
// Top level of the point-set minimum spanning tree core.
// Depends on psmst_pkg and psmst_dist.
//
// Points arrive one per cycle and are stored in load order, up to 64; a point that
// arrives with the store full is dropped, but its tlast still starts the build. The
// tlast point starts Prim's method from point 0 over all stored points when there are
// at least two (else it empties the store), and one edge transaction leaves per new
// tree member, the final one with tlast set. The build holds the input stalled. In
// each round, every tree member has its point fetched, then every outside point
// passes through the single read port of the point memory and the distance
// pipeline drains; each round ends with a swap of the order memory and the edge
// transfer.
module point_set_prim_mst_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // point_x[15:0], point_y[31:16]
  input  logic        s_axis_tlast,  // final_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // from_index[5:0], to_index[11:6],
                                     // squared_length[44:12], zero[47:45]
  output logic        m_axis_tlast   // last_edge
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROUND, S_A0, S_A1, S_A2, S_SCAN, S_DRAIN,
    S_SW0, S_SW1, S_SW2, S_SW3, S_SW4, S_EMIT
  } state_e;

  localparam psmst_pkg::cnt_t FullCnt = psmst_pkg::CntW'(psmst_pkg::MaxPoints);
  localparam psmst_pkg::cnt_t OneCnt  = psmst_pkg::CntW'(1);
  localparam psmst_pkg::cnt_t TwoCnt  = psmst_pkg::CntW'(2);

  state_e            state_q;
  psmst_pkg::cnt_t   loaded_q;
  psmst_pkg::cnt_t   n_q;
  psmst_pkg::cnt_t   ts_q;
  psmst_pkg::idx_t   j_q;
  psmst_pkg::idx_t   k_q;
  psmst_pkg::idx_t   bj_q;
  psmst_pkg::idx_t   bk_q;
  psmst_pkg::len_t   best_q;
  logic              have_q;
  psmst_pkg::idx_t   to_q;
  psmst_pkg::idx_t   old_ts_q;
  psmst_pkg::idx_t   from_q;
  psmst_pkg::point_t a_q;

  psmst_pkg::point_t pt_mem [psmst_pkg::MaxPoints];
  psmst_pkg::point_t pt_rd_q;
  psmst_pkg::idx_t   ord_mem [psmst_pkg::MaxPoints];
  logic [psmst_pkg::MaxPoints-1:0] ord_vld_q;
  psmst_pkg::idx_t   ord_rd_q;
  psmst_pkg::idx_t   ord_raddr;
  logic              ord_we;
  psmst_pkg::idx_t   ord_waddr;
  psmst_pkg::idx_t   ord_wdata;

  psmst_pkg::tag_t   s1_q;
  psmst_pkg::tag_t   s2_q;
  psmst_pkg::tag_t   s1_d;
  psmst_pkg::tag_t   dtag;
  psmst_pkg::sq_t    dx2;
  psmst_pkg::sq_t    dy2;
  logic              dist_busy;
  psmst_pkg::len_t   dist_sum;

  logic              in_acc;
  logic              pt_we;
  psmst_pkg::cnt_t   n_new;
  logic              out_free;
  logic              m_valid_q;
  psmst_pkg::idx_t   m_from_q;
  psmst_pkg::idx_t   m_to_q;
  psmst_pkg::len_t   m_len_q;
  logic              m_last_q;
  logic              emit_fire;
  logic              emit_last;
  logic              pipe_busy;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign pt_we     = in_acc && (loaded_q != FullCnt);
  assign n_new     = loaded_q + psmst_pkg::CntW'(pt_we);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign emit_fire = (state_q == S_EMIT) && out_free;
  assign emit_last = (ts_q + OneCnt) == n_q;
  assign pipe_busy = s1_q.valid || s2_q.valid || dist_busy;
  assign dist_sum  = {1'b0, dx2} + {1'b0, dy2};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_len_q, m_to_q, m_from_q};
  assign m_axis_tlast  = m_last_q;

  always_comb begin
    unique case (state_q)
      S_SCAN:  ord_raddr = k_q;
      S_SW0:   ord_raddr = bk_q;
      S_SW1:   ord_raddr = ts_q[psmst_pkg::IdxW-1:0];
      S_SW2:   ord_raddr = bj_q;
      default: ord_raddr = j_q;
    endcase
    ord_we    = (state_q == S_SW3) || (state_q == S_SW4);
    ord_waddr = (state_q == S_SW3) ? ts_q[psmst_pkg::IdxW-1:0] : bk_q;
    ord_wdata = (state_q == S_SW3) ? to_q : old_ts_q;
    s1_d.valid = (state_q == S_SCAN);
    s1_d.k     = k_q;
  end

  // Point memory: written while loading, read at the order-memory output.
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[loaded_q[psmst_pkg::IdxW-1:0]] <= {s_axis_tdata[31:16], s_axis_tdata[15:0]};
    end
    pt_rd_q <= pt_mem[ord_rd_q];
  end

  // Order memory: an entry never written since the last build reads as its own index.
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_vld_q[ord_raddr] ? ord_mem[ord_raddr] : ord_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_vld_q <= '0;
    end else if (emit_fire && emit_last) begin
      ord_vld_q <= '0;
    end else if (ord_we) begin
      ord_vld_q[ord_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  psmst_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s2_q),
    .pa_i   (a_q),
    .pb_i   (pt_rd_q),
    .tag_o  (dtag),
    .dx2_o  (dx2),
    .dy2_o  (dy2),
    .busy_o (dist_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      loaded_q  <= '0;
      n_q       <= '0;
      ts_q      <= OneCnt;
      j_q       <= '0;
      k_q       <= '0;
      bj_q      <= '0;
      bk_q      <= '0;
      best_q    <= '0;
      have_q    <= 1'b0;
      to_q      <= '0;
      old_ts_q  <= '0;
      from_q    <= '0;
      a_q       <= '0;
      m_valid_q <= 1'b0;
      m_from_q  <= '0;
      m_to_q    <= '0;
      m_len_q   <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tlast) begin
              ts_q <= OneCnt;
              if (n_new >= TwoCnt) begin
                n_q      <= n_new;
                loaded_q <= n_new;
                state_q  <= S_ROUND;
              end else begin
                loaded_q <= '0;
              end
            end else begin
              loaded_q <= n_new;
            end
          end
        end
        S_ROUND: begin
          have_q  <= 1'b0;
          j_q     <= '0;
          state_q <= S_A0;
        end
        S_A0: state_q <= S_A1;
        S_A1: state_q <= S_A2;
        S_A2: begin
          a_q     <= pt_rd_q;
          k_q     <= ts_q[psmst_pkg::IdxW-1:0];
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          k_q <= k_q + psmst_pkg::IdxW'(1);
          if ({1'b0, k_q} == n_q - OneCnt) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            j_q <= j_q + psmst_pkg::IdxW'(1);
            if (({1'b0, j_q} + OneCnt) == ts_q) begin
              state_q <= S_SW0;
            end else begin
              state_q <= S_A0;
            end
          end
        end
        S_SW0: state_q <= S_SW1;
        S_SW1: begin
          to_q    <= ord_rd_q;
          state_q <= S_SW2;
        end
        S_SW2: begin
          old_ts_q <= ord_rd_q;
          state_q  <= S_SW3;
        end
        S_SW3: begin
          from_q  <= ord_rd_q;
          state_q <= S_SW4;
        end
        S_SW4: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            m_from_q  <= from_q;
            m_to_q    <= to_q;
            m_len_q   <= best_q;
            m_last_q  <= emit_last;
            if (emit_last) begin
              ts_q     <= OneCnt;
              loaded_q <= '0;
              state_q  <= S_IDLE;
            end else begin
              ts_q    <= ts_q + OneCnt;
              state_q <= S_ROUND;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (dtag.valid && (!have_q || dist_sum < best_q)) begin
        have_q <= 1'b1;
        best_q <= dist_sum;
        bj_q   <= j_q;
        bk_q   <= dtag.k;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (ts_q < n_q))
    else $error("Tree size reached the point count during a build.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A1 || state_q == S_A2) |-> (!s1_q.valid && !s2_q.valid && !dist_busy))
    else $error("Tree point fetch overlaps the distance pipeline.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW0) |-> (have_q && {1'b0, bk_q} >= ts_q && {1'b0, bj_q} < ts_q))
    else $error("Chosen edge endpoints lie on the wrong side of the tree.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_last) |=> (state_q == S_IDLE && ord_vld_q == '0 && loaded_q == '0))
    else $error("Build state not cleared after the final edge.");

endmodule

// ===== design/psmst_dist.sv =====
// Two-stage squared distance pipeline: absolute differences, then squares.
// Uses the sizes and types of psmst_pkg.
module psmst_dist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psmst_pkg::tag_t   tag_i,
  input  psmst_pkg::point_t pa_i,
  input  psmst_pkg::point_t pb_i,
  output psmst_pkg::tag_t   tag_o,
  output psmst_pkg::sq_t    dx2_o,
  output psmst_pkg::sq_t    dy2_o,
  output logic              busy_o
);

  psmst_pkg::tag_t   tag1_q;
  psmst_pkg::tag_t   tag2_q;
  psmst_pkg::coord_t dx_q;
  psmst_pkg::coord_t dy_q;
  psmst_pkg::sq_t    dx2_q;
  psmst_pkg::sq_t    dy2_q;
  psmst_pkg::coord_t dx_d;
  psmst_pkg::coord_t dy_d;

  always_comb begin
    dx_d = (pa_i.x > pb_i.x) ? (pa_i.x - pb_i.x) : (pb_i.x - pa_i.x);
    dy_d = (pa_i.y > pb_i.y) ? (pa_i.y - pb_i.y) : (pb_i.y - pa_i.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dx2_q <= psmst_pkg::SqW'(dx_q) * psmst_pkg::SqW'(dx_q);
    dy2_q <= psmst_pkg::SqW'(dy_q) * psmst_pkg::SqW'(dy_q);
  end

  assign tag_o  = tag2_q;
  assign dx2_o  = dx2_q;
  assign dy2_o  = dy2_q;
  assign busy_o = tag1_q.valid | tag2_q.valid;

endmodule
